FILE: hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, operation codes and the queued request type of the
// fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FRAC_BITS_DEF   = 22;
	localparam int WORD_WIDTH_DEF  = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int PORT_WIDTH      = 32;
	localparam int OP_WIDTH        = 5;

	localparam logic [OP_WIDTH-1:0] OP_ADD      = 5'd0;
	localparam logic [OP_WIDTH-1:0] OP_SUB      = 5'd1;
	localparam logic [OP_WIDTH-1:0] OP_MUL      = 5'd2;
	localparam logic [OP_WIDTH-1:0] OP_DIV      = 5'd3;
	localparam logic [OP_WIDTH-1:0] OP_IADD     = 5'd4;
	localparam logic [OP_WIDTH-1:0] OP_ISUB     = 5'd5;
	localparam logic [OP_WIDTH-1:0] OP_IMUL     = 5'd6;
	localparam logic [OP_WIDTH-1:0] OP_IDIV     = 5'd7;
	localparam logic [OP_WIDTH-1:0] OP_LT       = 5'd8;
	localparam logic [OP_WIDTH-1:0] OP_GT       = 5'd9;
	localparam logic [OP_WIDTH-1:0] OP_LE       = 5'd10;
	localparam logic [OP_WIDTH-1:0] OP_GE       = 5'd11;
	localparam logic [OP_WIDTH-1:0] OP_EQ       = 5'd12;
	localparam logic [OP_WIDTH-1:0] OP_NE       = 5'd13;
	localparam logic [OP_WIDTH-1:0] OP_MIN      = 5'd14;
	localparam logic [OP_WIDTH-1:0] OP_MAX      = 5'd15;
	localparam logic [OP_WIDTH-1:0] OP_FROM_INT = 5'd16;
	localparam logic [OP_WIDTH-1:0] OP_TO_INT   = 5'd17;
	localparam logic [OP_WIDTH-1:0] OP_INC      = 5'd18;
	localparam logic [OP_WIDTH-1:0] OP_DEC      = 5'd19;

	typedef struct packed {
		logic [OP_WIDTH-1:0]          op;
		logic signed [PORT_WIDTH-1:0] a;
		logic signed [PORT_WIDTH-1:0] b;
		logic                         is_div;
		logic                         dz;
	} fpa_req_t;

endpackage

FILE: hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Accept requests, classify divides and zero divisors, and queue them for
// the execution side.
// ----------------------------------------------------------------------------
module fpa_front #(
	parameter int WORD_WIDTH  = fpa_pkg::WORD_WIDTH_DEF,
	parameter int QUEUE_DEPTH = fpa_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [fpa_pkg::OP_WIDTH-1:0]          operation,
	input  logic signed [fpa_pkg::PORT_WIDTH-1:0] operand_a,
	input  logic signed [fpa_pkg::PORT_WIDTH-1:0] operand_b,
	output logic                                  q_valid,
	output fpa_pkg::fpa_req_t                     q_head,
	input  logic                                  q_pop
);
	import fpa_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	fpa_req_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	fpa_req_t        req;
	logic            wr_en, rd_en;

	always_comb begin
		req.op     = operation;
		req.a      = operand_a;
		req.b      = operand_b;
		req.is_div = (operation == OP_DIV) || (operation == OP_IDIV);
		req.dz     = req.is_div && (operand_b[WORD_WIDTH-1:0] == '0);
	end

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_head  = mem_q[rd_ptr_q];
	assign wr_en   = push && !full;
	assign rd_en   = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpa_div #(
	parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [WORD_WIDTH+FRAC_BITS-1:0] dividend,
	input  logic [WORD_WIDTH-1:0]           divisor,
	output logic [WORD_WIDTH+FRAC_BITS-1:0] quotient,
	output logic                            done
);
	import fpa_pkg::*;

	localparam int N  = WORD_WIDTH + FRAC_BITS;
	localparam int CW = $clog2(N + 1);

	logic [N-1:0]          dvd_q;
	logic [WORD_WIDTH-1:0] dsr_q, rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, done_q;
	logic [WORD_WIDTH:0]   trial;
	logic                  fits;

	assign trial    = {rem_q, dvd_q[N-1]};
	assign fits     = (trial >= {1'b0, dsr_q});
	assign quotient = dvd_q;
	assign done     = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? WORD_WIDTH'(trial - {1'b0, dsr_q}) : trial[WORD_WIDTH-1:0];
			dvd_q <= {dvd_q[N-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(N);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

FILE: hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Execute queued requests: multiply stage, shared divider, result select
// and output register.
// ----------------------------------------------------------------------------
module fpa_back #(
	parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	input  fpa_pkg::fpa_req_t                     q_head,
	output logic                                  q_pop,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [fpa_pkg::PORT_WIDTH-1:0] result,
	output logic                                  flag,
	output logic                                  div_zero
);
	import fpa_pkg::*;

	localparam int W = WORD_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int N = W + F;

	logic signed [W-1:0]   ha, hb;
	logic [W-1:0]          ha_mag, hb_mag;
	logic [N-1:0]          dvd;
	logic                  div_start;
	logic [N-1:0]          quo;
	logic                  div_done;

	logic                  v_s1;
	logic [OP_WIDTH-1:0]   op_s1;
	logic signed [W-1:0]   a_s1, b_s1;
	logic signed [2*W-1:0] prod_s1;
	logic                  is_div_s1, dz_s1, neg_s1;

	logic                  s1_done, adv, ld;
	logic signed [W-1:0]   r, q_w, bsh;
	logic signed [2*W-1:0] prod_sh;
	logic                  f;

	logic                  out_v_q;

	assign ha     = q_head.a[W-1:0];
	assign hb     = q_head.b[W-1:0];
	assign ha_mag = ha[W-1] ? W'(-ha) : W'(ha);
	assign hb_mag = hb[W-1] ? W'(-hb) : W'(hb);
	assign dvd    = (q_head.op == OP_DIV) ? {ha_mag, {F{1'b0}}} : N'(ha_mag);

	assign s1_done   = !is_div_s1 || dz_s1 || div_done;
	assign adv       = v_s1 && s1_done && (!out_v_q || pop);
	assign ld        = q_valid && (!v_s1 || adv);
	assign q_pop     = ld;
	assign div_start = ld && q_head.is_div && !q_head.dz;
	assign empty     = !out_v_q;

	fpa_div #(
		.WORD_WIDTH (WORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (hb_mag),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (ld) begin
			op_s1     <= q_head.op;
			a_s1      <= ha;
			b_s1      <= hb;
			prod_s1   <= ha * hb;
			is_div_s1 <= q_head.is_div;
			dz_s1     <= q_head.dz;
			neg_s1    <= ha[W-1] ^ hb[W-1];
		end
	end

	always_comb begin
		bsh     = b_s1 <<< F;
		prod_sh = prod_s1 >>> F;
		q_w     = neg_s1 ? W'(-quo[W-1:0]) : quo[W-1:0];
		r       = '0;
		f       = 1'b0;
		case (op_s1) inside
			OP_ADD:      r = a_s1 + b_s1;
			OP_SUB:      r = a_s1 - b_s1;
			OP_MUL:      r = prod_sh[W-1:0];
			OP_DIV,
			OP_IDIV:     r = dz_s1 ? '0 : q_w;
			OP_IADD:     r = a_s1 + bsh;
			OP_ISUB:     r = a_s1 - bsh;
			OP_IMUL:     r = prod_s1[W-1:0];
			OP_LT:       f = a_s1 < b_s1;
			OP_GT:       f = a_s1 > b_s1;
			OP_LE:       f = a_s1 <= b_s1;
			OP_GE:       f = a_s1 >= b_s1;
			OP_EQ:       f = a_s1 == b_s1;
			OP_NE:       f = a_s1 != b_s1;
			OP_MIN:      r = (a_s1 < b_s1) ? a_s1 : b_s1;
			OP_MAX:      r = (a_s1 > b_s1) ? a_s1 : b_s1;
			OP_FROM_INT: r = a_s1 <<< F;
			OP_TO_INT:   r = a_s1 >>> F;
			OP_INC:      r = a_s1 + W'(1);
			OP_DEC:      r = a_s1 - W'(1);
			default:     r = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result   <= PORT_WIDTH'(r);
			flag     <= f;
			div_zero <= dz_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/fixed_point_q9_22_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_q9_22_alu_core
// Signed Q9.22 arithmetic unit with a request queue in front of a
// multiply/select pipeline and a shared one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
// Non-divide ops pass from the queue through stage 1 to the output register.
// Divides hold the back end in stage 1 until the divider raises done.
// Throughput: one request per cycle while results are popped and no divide is running.
// Reset: arst_n empties the queue and the pipeline; empty rises, full falls.
module fixed_point_q9_22_alu_core #(
	parameter int FRAC_BITS   = fpa_pkg::FRAC_BITS_DEF,
	parameter int WORD_WIDTH  = fpa_pkg::WORD_WIDTH_DEF,
	parameter int QUEUE_DEPTH = fpa_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [fpa_pkg::OP_WIDTH-1:0]          operation,
	input  logic signed [fpa_pkg::PORT_WIDTH-1:0] operand_a,
	input  logic signed [fpa_pkg::PORT_WIDTH-1:0] operand_b,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [fpa_pkg::PORT_WIDTH-1:0] result,
	output logic                                  flag,
	output logic                                  div_zero
);
	import fpa_pkg::*;

	logic     q_valid, q_pop;
	fpa_req_t q_head;

	fpa_front #(
		.WORD_WIDTH  (WORD_WIDTH),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	fpa_back #(
		.WORD_WIDTH (WORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.flag     (flag),
		.div_zero (div_zero)
	);

endmodule

FILE: hdl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks of the arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  empty,
	input logic                                  pop,
	input logic signed [fpa_pkg::PORT_WIDTH-1:0] result,
	input logic                                  flag,
	input logic                                  div_zero
);
	import fpa_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result) && $stable(flag) && $stable(div_zero))
		else $error("stalled result changed");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && div_zero |-> result == '0 && !flag)
		else $error("zero divisor with nonzero result");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && flag |-> result == '0)
		else $error("comparison with nonzero result");

endmodule

bind fixed_point_q9_22_alu_core fpa_checker u_fpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.result   (result),
	.flag     (flag),
	.div_zero (div_zero)
);
